@@ rtl/tre_pkg.sv @@
package tre_pkg;

  localparam int TILE_W    = 48;
  localparam int CNT_W     = 6;
  localparam int BUF_DEPTH = 63;
  localparam int BUF_AW    = 6;
  localparam int CAP_LIMIT = 63;

  typedef struct packed {
    logic [15:0]        floor_id;
    logic [15:0]        wall_id;
    logic [7:0]         item_id;
    logic signed [7:0]  light_level;
    logic               end_of_map;
  } tile_req_t;

  typedef struct packed {
    logic               is_tile;
    logic signed [7:0]  run_count;
    logic [15:0]        out_floor;
    logic [15:0]        out_wall;
    logic [7:0]         out_item;
    logic signed [7:0]  out_light;
    logic               last_of_burst;
    logic               map_done;
  } result_req_t;

  typedef enum logic [1:0] {
    SEG_NONE,
    SEG_REP,
    SEG_LIT
  } seg_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HDR,
    S_REP_TILE,
    S_LIT_TILE
  } tre_state_t;

endpackage

@@ rtl/tre_stream_if.sv @@
interface tre_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/tile_rle_encoder.sv @@
// a tile that closes no run is taken and gives no result
// a tile that closes runs is taken, then the encoder leaves S_IDLE and gives one
// result per cycle while the sink takes them; no new tile is taken until it is back in S_IDLE
// throughput: one result per cycle while the sink takes them, set by the single read port of the
// literal buffer memory and the output register
// reset: control state cleared synchronously, buffer contents left undefined
module tile_rle_encoder #(
  parameter int MAX_RUN = 63
) (
  input logic         clk,
  input logic         rst,
  tre_stream_if.sink   tiles,
  tre_stream_if.source stream
);

  import tre_pkg::*;

  localparam int RUN_CAP = (MAX_RUN > CAP_LIMIT) ? CAP_LIMIT :
                           ((MAX_RUN < 2) ? 2 : MAX_RUN);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(RUN_CAP);

  tre_state_t        state, state_next;
  logic              seg_sel, seg_sel_next;
  logic              active, active_n;
  logic [TILE_W-1:0] rep_tile, rep_n;
  logic [CNT_W-1:0]  sc, sc_n;
  logic [CNT_W-1:0]  lc, lc_n;
  seg_kind_t         s1_kind, s1_kind_n, s2_kind, s2_kind_n;
  logic [CNT_W-1:0]  s1_n, s1_n_n, s2_n, s2_n_n;
  logic [TILE_W-1:0] seg_tile;
  logic              last_q;
  logic              wb_pending;
  logic [CNT_W-1:0]  idx, idx_next;
  result_req_t       out_q, res_next;
  logic              out_valid;
  logic              load;

  logic              plan_we, plan_defer;
  logic [BUF_AW-1:0] plan_addr;

  logic              mem_we, mem_re;
  logic [BUF_AW-1:0] mem_waddr, mem_raddr;
  logic [TILE_W-1:0] mem_wdata, mem_rdata;

  logic              accept, slot_free, final_seg, seg_end;
  seg_kind_t         cur_kind;
  logic [CNT_W-1:0]  cur_n;
  logic [TILE_W-1:0] t_in;
  logic [CNT_W:0]    sc_inc;
  logic signed [7:0] hdr_count;

  function automatic result_req_t tile_result(logic [TILE_W-1:0] t, logic fin,
                                              logic done);
    result_req_t r;
    r.is_tile       = 1'b1;
    r.run_count     = '0;
    r.out_floor     = t[47:32];
    r.out_wall      = t[31:16];
    r.out_item      = t[15:8];
    r.out_light     = t[7:0];
    r.last_of_burst = fin;
    r.map_done      = done;
    return r;
  endfunction

  function automatic result_req_t hdr_result(logic signed [7:0] n);
    result_req_t r;
    r               = '0;
    r.run_count     = n;
    return r;
  endfunction

  tre_ram #(
    .WIDTH (TILE_W),
    .DEPTH (BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign t_in = {tiles.payload.floor_id, tiles.payload.wall_id,
                 tiles.payload.item_id, tiles.payload.light_level};
  assign tiles.ready    = (state == S_IDLE);
  assign accept         = tiles.valid && tiles.ready;
  assign stream.valid   = out_valid;
  assign stream.payload = out_q;
  assign slot_free      = !out_valid || stream.ready;
  assign cur_kind       = seg_sel ? s2_kind : s1_kind;
  assign cur_n          = seg_sel ? s2_n : s1_n;
  assign final_seg      = seg_sel || (s2_kind == SEG_NONE);
  assign sc_inc         = {1'b0, sc} + 1'b1;
  assign hdr_count      = (cur_kind == SEG_REP) ? -$signed({2'b00, cur_n}) :
                                                  $signed({2'b00, cur_n});

  // run decisions for the tile on offer
  always_comb begin
    active_n   = active;
    rep_n      = rep_tile;
    sc_n       = sc;
    lc_n       = lc;
    s1_kind_n  = SEG_NONE;
    s1_n_n     = '0;
    s2_kind_n  = SEG_NONE;
    s2_n_n     = '0;
    plan_we    = 1'b0;
    plan_defer = 1'b0;
    plan_addr  = '0;
    if (!active || (t_in == rep_tile && sc_inc > {1'b0, CAP}) ||
        (t_in != rep_tile && sc >= CNT_W'(2))) begin
      if (active) begin
        s1_kind_n = SEG_REP;
        s1_n_n    = (t_in == rep_tile) ? CAP : sc;
      end
      active_n = 1'b1;
      rep_n    = t_in;
      sc_n     = CNT_W'(1);
      lc_n     = CNT_W'(1);
      plan_we  = 1'b1;
    end else if (t_in == rep_tile) begin
      sc_n = sc_inc[CNT_W-1:0];
      if (sc_inc == (CNT_W+1)'(2) && lc > CNT_W'(1)) begin
        s1_kind_n  = SEG_LIT;
        s1_n_n     = lc - 1'b1;
        lc_n       = CNT_W'(1);
        plan_we    = 1'b1;
        plan_defer = 1'b1;
      end
    end else begin
      if (lc != CNT_W'(BUF_DEPTH)) begin
        plan_we   = 1'b1;
        plan_addr = lc;
        lc_n      = lc + 1'b1;
      end
      rep_n = t_in;
      sc_n  = CNT_W'(1);
    end
    if (active_n && sc_n == CNT_W'(1) && lc_n >= CAP) begin
      s2_kind_n = SEG_LIT;
      s2_n_n    = lc_n;
      active_n  = 1'b0;
      lc_n      = CNT_W'(1);
    end
    if (tiles.payload.end_of_map && active_n) begin
      if (sc_n > CNT_W'(1)) begin
        s2_kind_n = SEG_REP;
        s2_n_n    = sc_n;
      end else begin
        s2_kind_n = SEG_LIT;
        s2_n_n    = lc_n;
      end
      active_n = 1'b0;
      sc_n     = CNT_W'(1);
      lc_n     = CNT_W'(1);
    end
  end

  always_comb begin
    state_next   = state;
    seg_sel_next = seg_sel;
    idx_next     = idx;
    load         = 1'b0;
    res_next     = hdr_result(hdr_count);
    mem_we       = 1'b0;
    mem_waddr    = plan_addr;
    mem_wdata    = t_in;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    seg_end      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          mem_we = plan_we && !plan_defer;
          if (s1_kind_n != SEG_NONE) begin
            state_next   = S_HDR;
            seg_sel_next = 1'b0;
          end else if (s2_kind_n != SEG_NONE) begin
            state_next   = S_HDR;
            seg_sel_next = 1'b1;
          end
        end
      end
      S_HDR: begin
        if (slot_free) begin
          load = 1'b1;
          if (cur_kind == SEG_LIT) begin
            mem_re     = 1'b1;
            idx_next   = '0;
            state_next = S_LIT_TILE;
          end else begin
            state_next = S_REP_TILE;
          end
        end
      end
      S_REP_TILE: begin
        if (slot_free) begin
          load     = 1'b1;
          res_next = tile_result(seg_tile, final_seg, final_seg && last_q);
          seg_end  = 1'b1;
        end
      end
      S_LIT_TILE: begin
        if (slot_free) begin
          load = 1'b1;
          if (idx == cur_n - 1'b1) begin
            res_next = tile_result(mem_rdata, final_seg, final_seg && last_q);
            seg_end  = 1'b1;
            // repeat pair start goes to the front once the old literals are out
            if (!seg_sel && wb_pending) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = seg_tile;
            end
          end else begin
            res_next  = tile_result(mem_rdata, 1'b0, 1'b0);
            mem_re    = 1'b1;
            mem_raddr = idx + 1'b1;
            idx_next  = idx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (seg_end) begin
      if (!seg_sel && s2_kind != SEG_NONE) begin
        state_next   = S_HDR;
        seg_sel_next = 1'b1;
      end else begin
        state_next = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      seg_sel    <= 1'b0;
      active     <= 1'b0;
      rep_tile   <= '0;
      sc         <= CNT_W'(1);
      lc         <= CNT_W'(1);
      s1_kind    <= SEG_NONE;
      s2_kind    <= SEG_NONE;
      wb_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state   <= state_next;
      seg_sel <= seg_sel_next;
      if (accept) begin
        active     <= active_n;
        rep_tile   <= rep_n;
        sc         <= sc_n;
        lc         <= lc_n;
        s1_kind    <= s1_kind_n;
        s2_kind    <= s2_kind_n;
        wb_pending <= plan_defer;
      end else if (mem_we) begin
        wb_pending <= 1'b0;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (accept) begin
      s1_n     <= s1_n_n;
      s2_n     <= s2_n_n;
      seg_tile <= rep_tile;
      last_q   <= tiles.payload.end_of_map;
    end
    if (load) begin
      out_q <= res_next;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    state == S_LIT_TILE |-> idx < cur_n)
    else $error("literal read index past run length");

  assert property (@(posedge clk) disable iff (rst)
    active |-> (lc != '0 && lc < CAP))
    else $error("open literal run outside buffer bounds");

  assert property (@(posedge clk) disable iff (rst)
    sc != '0 && sc <= CAP)
    else $error("repeat length outside cap");

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_IDLE || (state == S_LIT_TILE && wb_pending && !seg_sel)))
    else $error("buffer write outside accept or deferred write-back");
`endif

endmodule

@@ rtl/tre_ram.sv @@
module tre_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 63,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
